// File: src/smith_waterman_local_align_defines.svh
// ----------------------------------------------------------------------------
// smith_waterman_local_align defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef SMITH_WATERMAN_LOCAL_ALIGN_DEFINES_SVH
`define SMITH_WATERMAN_LOCAL_ALIGN_DEFINES_SVH

// same-cycle implication
`define SWLA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swla assertion failed");

// next-cycle implication
`define SWLA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swla assertion failed");

`endif

// File: src/swla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swla_pkg
// shared constants and types of the local alignment block
// ----------------------------------------------------------------------------
package swla_pkg;

    localparam int SYM_W     = 5;
    localparam int LANES     = 32;
    localparam int NUM_CELLS = 32;
    localparam int MAX_LEN_A = 32;
    localparam int MAX_LEN_B = 32;
    localparam int ALPHABET  = 32;
    localparam int SCORE_W   = 16;
    localparam int ROW_W     = LANES * SCORE_W;
    localparam int H_W       = 21;
    localparam int CALC_W    = H_W + 2;
    localparam int IDX_W     = 6;
    localparam int MAX_PATH  = 63;
    localparam int DIR_W     = 2;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DIAG = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT = 2'd3;

    localparam logic [1:0] OP_TABLE    = 2'd0;
    localparam logic [1:0] OP_APPEND_A = 2'd1;
    localparam logic [1:0] OP_APPEND_B = 2'd2;
    localparam logic [1:0] OP_GO       = 2'd3;

    typedef struct packed {
        logic               clear;
        logic               prof_we;
        logic [SYM_W-1:0]   prof_addr;
        logic [SYM_W-1:0]   tb_row;
        logic [SCORE_W-1:0] gap;
        logic               b_we;
        logic [SYM_W-1:0]   b_sym;
    } cell_ctrl_t;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] a_sym;
        logic [SYM_W-1:0] row;
        logic [H_W-1:0]   h;
    } cell_link_t;

    typedef struct packed {
        logic [H_W-1:0]   score;
        logic [SYM_W-1:0] row;
    } cell_best_t;

endpackage

// File: src/smith_waterman_local_align.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smith_waterman_local_align
// local alignment of two short symbol sequences with a linear gap penalty
// ----------------------------------------------------------------------------
// After reset the substitution table is cleared one row a cycle, during
// which no transaction is accepted. A go transaction then loads the score
// profiles into the 32-cell column chain from the 32-row table memory,
// fills the wavefront through the chain, scans the cells for the best
// score, traces back one column per cycle, detects the end of the path,
// and emits each column by a path memory read, then an output register
// write, which waits while the downstream side stalls. With an empty
// sequence the fill, scan and traceback are skipped and the single empty
// result follows the profile load. The input side is held off from go
// until the last result is loaded into the output register.
// ----------------------------------------------------------------------------
module smith_waterman_local_align (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // gap_penalty
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // table_index, table_value, symbol, pad
    input  logic [1:0]  s_tuser,        // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,        // best_score, path_len, index_a, index_b, pad
    output logic        m_tlast
);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_LOAD    = 4'd2;
    localparam logic [3:0] ST_FILL    = 4'd3;
    localparam logic [3:0] ST_SCAN    = 4'd4;
    localparam logic [3:0] ST_TRACE   = 4'd5;
    localparam logic [3:0] ST_EMIT_RD = 4'd6;
    localparam logic [3:0] ST_EMIT_WR = 4'd7;
    localparam logic [3:0] ST_ZERO    = 4'd8;

    localparam int SYM_W = swla_pkg::SYM_W;
    localparam int H_W   = swla_pkg::H_W;
    localparam int IDX_W = swla_pkg::IDX_W;

    logic [3:0]                   state_reg;
    logic [3:0]                   state_next;
    logic [5:0]                   cnt_reg;
    logic [5:0]                   cnt_next;
    logic [IDX_W-1:0]             len_a_reg;
    logic [IDX_W-1:0]             len_a_next;
    logic [IDX_W-1:0]             len_b_reg;
    logic [IDX_W-1:0]             len_b_next;
    logic [15:0]                  gap_reg;
    logic [H_W-1:0]               gbest_reg;
    logic [H_W-1:0]               gbest_next;
    logic [IDX_W-1:0]             ti_reg;
    logic [IDX_W-1:0]             ti_next;
    logic [IDX_W-1:0]             tj_reg;
    logic [IDX_W-1:0]             tj_next;
    logic [IDX_W-1:0]             k_reg;
    logic [IDX_W-1:0]             k_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [38:0]                  out_data_reg;
    logic [38:0]                  out_data_next;
    logic                         out_last_reg;
    logic                         out_last_next;

    logic [swla_pkg::ROW_W-1:0]   tbl_mem [swla_pkg::LANES];
    logic [swla_pkg::ROW_W-1:0]   tbl_rd_reg;
    logic [SYM_W-1:0]             seq_a_mem [swla_pkg::MAX_LEN_A];
    logic [2*IDX_W-1:0]           path_mem [swla_pkg::MAX_PATH];
    logic [2*IDX_W-1:0]           path_rd_reg;

    logic [1:0]                   in_op;
    logic [9:0]                   in_index;
    logic [15:0]                  in_value;
    logic [SYM_W-1:0]             in_sym;
    logic                         in_acc;
    logic                         tbl_we;
    logic                         clr_we;
    logic                         seq_a_we;
    logic                         path_we;
    logic [2*IDX_W-1:0]           path_wdata;
    logic                         out_free;

    swla_pkg::cell_ctrl_t         ctrl;
    swla_pkg::cell_link_t         feed;
    swla_pkg::cell_link_t         link [swla_pkg::NUM_CELLS];
    swla_pkg::cell_best_t         cbest [swla_pkg::NUM_CELLS];
    logic [swla_pkg::DIR_W-1:0]   cdir [swla_pkg::NUM_CELLS];
    logic [swla_pkg::NUM_CELLS-1:0] b_sel;

    swla_pkg::cell_best_t         scan_best;
    logic                         scan_take;
    logic [swla_pkg::DIR_W-1:0]   tb_dir;
    logic [IDX_W-1:0]             ti_m1;
    logic [IDX_W-1:0]             tj_m1;
    logic [6:0]                   fill_end;

    assign in_op    = s_tuser;
    assign in_index = s_tdata[9:0];
    assign in_value = s_tdata[25:10];
    assign in_sym   = s_tdata[30:26];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign tbl_we   = in_acc && (in_op == swla_pkg::OP_TABLE)
                   && ({1'b0, in_index[9:5]} < 6'(swla_pkg::ALPHABET))
                   && ({1'b0, in_index[4:0]} < 6'(swla_pkg::ALPHABET));
    assign clr_we   = (state_reg == ST_CLEAR);
    assign seq_a_we = in_acc && (in_op == swla_pkg::OP_APPEND_A)
                   && (len_a_reg < IDX_W'(swla_pkg::MAX_LEN_A));

    assign ti_m1    = ti_reg - 1'b1;
    assign tj_m1    = tj_reg - 1'b1;
    assign fill_end = {1'b0, len_a_reg} + {1'b0, len_b_reg} - 7'd2;

    // cell control
    always_comb
    begin
        ctrl.clear     = (state_reg == ST_LOAD);
        ctrl.prof_we   = (state_reg == ST_LOAD) && (cnt_reg != 6'd0);
        ctrl.prof_addr = 5'(cnt_reg - 1'b1);
        ctrl.tb_row    = ti_m1[SYM_W-1:0];
        ctrl.gap       = gap_reg;
        ctrl.b_we      = in_acc && (in_op == swla_pkg::OP_APPEND_B)
                      && (len_b_reg < IDX_W'(swla_pkg::MAX_LEN_B));
        ctrl.b_sym     = in_sym;
        b_sel          = '0;
        b_sel[len_b_reg[SYM_W-1:0]] = 1'b1;
        feed.valid     = (state_reg == ST_FILL) && (cnt_reg < len_a_reg);
        feed.a_sym     = seq_a_mem[cnt_reg[SYM_W-1:0]];
        feed.row       = cnt_reg[SYM_W-1:0];
        feed.h         = '0;
    end

    genvar g;
    generate
        for (g = 0; g < swla_pkg::NUM_CELLS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                swla_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (ctrl),
                    .b_sel    (b_sel[g]),
                    .row_word (tbl_rd_reg),
                    .left     (feed),
                    .right    (link[g]),
                    .best     (cbest[g]),
                    .dir_rd   (cdir[g])
                );
            end
            else
            begin : g_rest
                swla_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctrl     (ctrl),
                    .b_sel    (b_sel[g]),
                    .row_word (tbl_rd_reg),
                    .left     (link[g-1]),
                    .right    (link[g]),
                    .best     (cbest[g]),
                    .dir_rd   (cdir[g])
                );
            end
        end
    endgenerate

    // substitution table, one row per a symbol
    always_ff @(posedge clk)
    begin
        if (clr_we)
        begin
            tbl_mem[cnt_reg[SYM_W-1:0]] <= '0;
        end
        else if (tbl_we)
        begin
            tbl_mem[in_index[9:5]][swla_pkg::SCORE_W * in_index[4:0] +: swla_pkg::SCORE_W]
                <= in_value;
        end
        tbl_rd_reg <= tbl_mem[cnt_reg[SYM_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (seq_a_we)
        begin
            seq_a_mem[len_a_reg[SYM_W-1:0]] <= in_sym;
        end
    end

    // traceback path
    always_ff @(posedge clk)
    begin
        if (path_we)
        begin
            path_mem[k_reg] <= path_wdata;
        end
        path_rd_reg <= path_mem[cnt_reg];
    end

    always_comb
    begin
        scan_best = cbest[cnt_reg[SYM_W-1:0]];
        scan_take = (scan_best.score > gbest_reg)
                 || ((scan_best.score == gbest_reg) && (scan_best.score != '0)
                     && ({1'b0, scan_best.row} < ti_m1));
        tb_dir    = cdir[tj_m1[SYM_W-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        len_a_next     = len_a_reg;
        len_b_next     = len_b_reg;
        gbest_next     = gbest_reg;
        ti_next        = ti_reg;
        tj_next        = tj_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        path_we        = 1'b0;
        path_wdata     = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'(swla_pkg::LANES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_op)
                        swla_pkg::OP_APPEND_A:
                        begin
                            if (seq_a_we)
                            begin
                                len_a_next = len_a_reg + 1'b1;
                            end
                        end
                        swla_pkg::OP_APPEND_B:
                        begin
                            if (ctrl.b_we)
                            begin
                                len_b_next = len_b_reg + 1'b1;
                            end
                        end
                        swla_pkg::OP_GO:
                        begin
                            cnt_next   = '0;
                            gbest_next = '0;
                            ti_next    = '0;
                            tj_next    = '0;
                            k_next     = '0;
                            state_next = ST_LOAD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'(swla_pkg::LANES))
                begin
                    cnt_next = '0;
                    if ((len_a_reg == '0) || (len_b_reg == '0))
                    begin
                        state_next = ST_ZERO;
                    end
                    else
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if ({1'b0, cnt_reg} == fill_end)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (scan_take)
                begin
                    gbest_next = scan_best.score;
                    ti_next    = {1'b0, scan_best.row} + 1'b1;
                    tj_next    = cnt_reg + 1'b1;
                end
                if (cnt_reg == len_b_reg - 1'b1)
                begin
                    cnt_next = '0;
                    if (gbest_next == '0)
                    begin
                        state_next = ST_ZERO;
                    end
                    else
                    begin
                        state_next = ST_TRACE;
                    end
                end
            end
            ST_TRACE:
            begin
                if ((ti_reg == '0) || (tj_reg == '0) || (k_reg == 6'(swla_pkg::MAX_PATH))
                    || (tb_dir == swla_pkg::DIR_STOP))
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    path_we = 1'b1;
                    k_next  = k_reg + 1'b1;
                    case (tb_dir)
                        swla_pkg::DIR_DIAG:
                        begin
                            path_wdata = {tj_m1, ti_m1};
                            ti_next    = ti_m1;
                            tj_next    = tj_m1;
                        end
                        swla_pkg::DIR_UP:
                        begin
                            path_wdata = {{IDX_W{1'b1}}, ti_m1};
                            ti_next    = ti_m1;
                        end
                        default:
                        begin
                            path_wdata = {tj_m1, {IDX_W{1'b1}}};
                            tj_next    = tj_m1;
                        end
                    endcase
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {path_rd_reg, k_reg, gbest_reg};
                    out_last_next  = (cnt_reg == k_reg - 1'b1);
                    cnt_next       = cnt_reg + 1'b1;
                    if (cnt_reg == k_reg - 1'b1)
                    begin
                        len_a_next = '0;
                        len_b_next = '0;
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(2*IDX_W){1'b1}}, {IDX_W{1'b0}}, {H_W{1'b0}}};
                    out_last_next  = 1'b1;
                    len_a_next     = '0;
                    len_b_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            gap_reg       <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            len_a_reg     <= len_a_next;
            len_b_reg     <= len_b_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            if (cfg_we)
            begin
                gap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gbest_reg    <= gbest_next;
        ti_reg       <= ti_next;
        tj_reg       <= tj_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: src/swla_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swla_cell
// one column of the score grid: holds a b symbol, its score profile,
// its column of directions and its best cell
// ----------------------------------------------------------------------------
module swla_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swla_pkg::cell_ctrl_t          ctrl,
    input  logic                          b_sel,
    input  logic [swla_pkg::ROW_W-1:0]    row_word,
    input  swla_pkg::cell_link_t          left,
    output swla_pkg::cell_link_t          right,
    output swla_pkg::cell_best_t          best,
    output logic [swla_pkg::DIR_W-1:0]    dir_rd
);

    logic [swla_pkg::SYM_W-1:0]   b_sym_reg;
    logic [swla_pkg::SCORE_W-1:0] prof_mem [swla_pkg::LANES];
    logic [swla_pkg::DIR_W-1:0]   dir_mem [swla_pkg::LANES];
    logic [swla_pkg::H_W-1:0]     h_reg;
    logic [swla_pkg::H_W-1:0]     diag_reg;
    logic                         valid_reg;
    logic [swla_pkg::SYM_W-1:0]   a_reg;
    logic [swla_pkg::SYM_W-1:0]   row_reg;
    logic [swla_pkg::H_W-1:0]     best_score_reg;
    logic [swla_pkg::SYM_W-1:0]   best_row_reg;

    logic [swla_pkg::SCORE_W-1:0]        sub;
    logic signed [swla_pkg::CALC_W-1:0]  match_s;
    logic signed [swla_pkg::CALC_W-1:0]  del_s;
    logic signed [swla_pkg::CALC_W-1:0]  ins_s;
    logic signed [swla_pkg::CALC_W-1:0]  gap_s;
    logic signed [swla_pkg::CALC_W-1:0]  score_s;
    logic [swla_pkg::DIR_W-1:0]          dir_next;
    logic [swla_pkg::H_W-1:0]            h_next;

    always_comb
    begin
        sub     = prof_mem[left.a_sym];
        gap_s   = {{(swla_pkg::CALC_W - swla_pkg::SCORE_W){ctrl.gap[swla_pkg::SCORE_W-1]}},
                   ctrl.gap};
        match_s = signed'({2'b00, diag_reg})
                + signed'({{(swla_pkg::CALC_W - swla_pkg::SCORE_W){sub[swla_pkg::SCORE_W-1]}},
                           sub});
        del_s   = signed'({2'b00, h_reg}) + gap_s;
        ins_s   = signed'({2'b00, left.h}) + gap_s;
        score_s = '0;
        if (match_s > score_s)
        begin
            score_s = match_s;
        end
        if (del_s > score_s)
        begin
            score_s = del_s;
        end
        if (ins_s > score_s)
        begin
            score_s = ins_s;
        end
        dir_next = swla_pkg::DIR_STOP;
        if (score_s > 0)
        begin
            if (score_s == match_s)
            begin
                dir_next = swla_pkg::DIR_DIAG;
            end
            else if (score_s == del_s)
            begin
                dir_next = swla_pkg::DIR_UP;
            end
            else
            begin
                dir_next = swla_pkg::DIR_LEFT;
            end
        end
        h_next = score_s[swla_pkg::H_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= left.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.b_we && b_sel)
        begin
            b_sym_reg <= ctrl.b_sym;
        end
        if (ctrl.prof_we)
        begin
            prof_mem[ctrl.prof_addr] <=
                row_word[swla_pkg::SCORE_W * b_sym_reg +: swla_pkg::SCORE_W];
        end
        if (left.valid)
        begin
            dir_mem[left.row] <= dir_next;
        end
        a_reg   <= left.a_sym;
        row_reg <= left.row;
        if (ctrl.clear)
        begin
            h_reg          <= '0;
            diag_reg       <= '0;
            best_score_reg <= '0;
            best_row_reg   <= '0;
        end
        else
        begin
            diag_reg <= left.h;
            if (left.valid)
            begin
                h_reg <= h_next;
                if (h_next > best_score_reg)
                begin
                    best_score_reg <= h_next;
                    best_row_reg   <= left.row;
                end
            end
        end
    end

    assign right.valid = valid_reg;
    assign right.a_sym = a_reg;
    assign right.row   = row_reg;
    assign right.h     = h_reg;
    assign best.score  = best_score_reg;
    assign best.row    = best_row_reg;
    assign dir_rd      = dir_mem[ctrl.tb_row];

endmodule

// File: src/swla_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swla_checker
// port-level checks of the local alignment block
// ----------------------------------------------------------------------------
`include "smith_waterman_local_align_defines.svh"

module swla_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    `SWLA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `SWLA_ASSERT_NOW(a_empty_run, m_tvalid && (m_tdata[26:21] == 6'd0), m_tlast && (m_tdata[20:0] == 21'd0) && (m_tdata[32:27] == 6'h3F) && (m_tdata[38:33] == 6'h3F))
    `SWLA_ASSERT_NOW(a_no_input_midrun, m_tvalid && !m_tlast, !s_tready)
    `SWLA_ASSERT_NOW(a_column_not_double_gap, m_tvalid && (m_tdata[26:21] != 6'd0), (m_tdata[20:0] != 21'd0) && !((m_tdata[32:27] == 6'h3F) && (m_tdata[38:33] == 6'h3F)))

endmodule

bind smith_waterman_local_align swla_checker u_swla_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the local alignment block
// ----------------------------------------------------------------------------
// Streams table writes, symbol appends and go transactions into the block.
// A scoreboard model fills the score grid and traces back to build the
// expected alignment columns. Every result is then compared field by field,
// oldest first. Random idling is applied on both sides, and the gap penalty
// is swept between phases, its extremes included.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [20:0] best;
        logic [5:0]  plen;
        logic [5:0]  ia;
        logic [5:0]  ib;
        logic        last;
    } column_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    int          sub_score [1024];
    logic [4:0]  seq_a [32];
    logic [4:0]  seq_b [32];
    int          len_a;
    int          len_b;
    int          gap;
    column_t     columns_due [$];
    int          errors = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles = 0;

    localparam int WATCHDOG_LIMIT = 5000;

    smith_waterman_local_align dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // score grid fill and traceback
    task automatic align_and_queue();
        int h [33][33];
        logic [1:0] dir [33][33];
        int best;
        int bi;
        int bj;
        int i;
        int j;
        int k;
        int mt;
        int dl;
        int ins;
        int sc;
        int pa [$];
        int pb [$];
        column_t c;
        best = 0;
        bi = 0;
        bj = 0;
        for (i = 0; i <= 32; i++)
        begin
            h[i][0] = 0;
            h[0][i] = 0;
        end
        for (i = 1; i <= len_a; i++)
        begin
            for (j = 1; j <= len_b; j++)
            begin
                mt = h[i-1][j-1] + sub_score[{seq_a[i-1], seq_b[j-1]}];
                dl = h[i-1][j] + gap;
                ins = h[i][j-1] + gap;
                sc = 0;
                if (mt > sc) sc = mt;
                if (dl > sc) sc = dl;
                if (ins > sc) sc = ins;
                if (sc <= 0) dir[i][j] = swla_pkg::DIR_STOP;
                else if (sc == mt) dir[i][j] = swla_pkg::DIR_DIAG;
                else if (sc == dl) dir[i][j] = swla_pkg::DIR_UP;
                else dir[i][j] = swla_pkg::DIR_LEFT;
                h[i][j] = sc;
                if (sc > best)
                begin
                    best = sc;
                    bi = i;
                    bj = j;
                end
            end
        end
        len_a = 0;
        len_b = 0;
        if (best <= 0)
        begin
            c.best = '0;
            c.plen = '0;
            c.ia = 6'h3f;
            c.ib = 6'h3f;
            c.last = 1'b1;
            columns_due.push_back(c);
            return;
        end
        i = bi;
        j = bj;
        while (i > 0 && j > 0 && pa.size() < swla_pkg::MAX_PATH
               && dir[i][j] != swla_pkg::DIR_STOP)
        begin
            if (dir[i][j] == swla_pkg::DIR_DIAG)
            begin
                pa.push_back(i - 1);
                pb.push_back(j - 1);
                i--;
                j--;
            end
            else if (dir[i][j] == swla_pkg::DIR_UP)
            begin
                pa.push_back(i - 1);
                pb.push_back(-1);
                i--;
            end
            else
            begin
                pa.push_back(-1);
                pb.push_back(j - 1);
                j--;
            end
        end
        for (k = 0; k < pa.size(); k++)
        begin
            c.best = best[20:0];
            c.plen = 6'(pa.size());
            c.ia = pa[k][5:0];
            c.ib = pb[k][5:0];
            c.last = (k == pa.size() - 1);
            columns_due.push_back(c);
        end
    endtask

    task automatic apply_item(logic [1:0] op, logic [9:0] idx, logic [15:0] val,
                              logic [4:0] sym);
        case (op)
            swla_pkg::OP_TABLE:    sub_score[idx] = $signed(val);
            swla_pkg::OP_APPEND_A: if (len_a < swla_pkg::MAX_LEN_A) seq_a[len_a++] = sym;
            swla_pkg::OP_APPEND_B: if (len_b < swla_pkg::MAX_LEN_B) seq_b[len_b++] = sym;
            default:               align_and_queue();
        endcase
    endtask

    task automatic send_item(logic [1:0] op, logic [9:0] idx, logic [15:0] val,
                             logic [4:0] sym);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, sym, val, idx};
        do @(posedge clk); while (!s_tready);
        apply_item(op, idx, val, sym);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_gap(logic [15:0] value);
        end_burst();
        while (columns_due.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        gap = $signed(value);
    endtask

    task automatic random_noise();
        send_item(2'($urandom_range(2)), 10'($urandom), 16'($urandom), 5'($urandom));
    endtask

    // one job with random content: table edits, two sequences, go, with stray items mixed in
    task automatic random_job(output int sent);
        int alpha;
        int la;
        int lb;
        int n;
        alpha = ($urandom_range(3) == 0) ? 32 : $urandom_range(6, 2);
        la = ($urandom_range(9) == 0) ? $urandom_range(32, 9) : $urandom_range(8);
        lb = ($urandom_range(9) == 0) ? $urandom_range(32, 9) : $urandom_range(8);
        sent = 0;
        repeat ($urandom_range(4))
        begin
            if ($urandom_range(4) == 0)
                send_item(swla_pkg::OP_TABLE, 10'($urandom), 16'($urandom), 5'($urandom));
            else
                send_item(swla_pkg::OP_TABLE, {5'($urandom_range(alpha - 1)),
                          5'($urandom_range(alpha - 1))},
                          16'($signed($urandom_range(24)) - 10), 5'($urandom));
            sent++;
        end
        for (n = 0; n < la + lb; n++)
        begin
            if ($urandom_range(15) == 0)
            begin
                random_noise();
                sent++;
            end
            send_item(n < la ? swla_pkg::OP_APPEND_A : swla_pkg::OP_APPEND_B,
                      10'($urandom), 16'($urandom), 5'($urandom_range(alpha - 1)));
        end
        send_item(swla_pkg::OP_GO, 10'($urandom), 16'($urandom), 5'($urandom));
        sent += la + lb + 1;
    endtask

    task automatic test_directed();
        write_gap(16'hffff);
        send_item(swla_pkg::OP_GO, 10'h3ff, 16'hffff, 5'h1f);
        send_item(swla_pkg::OP_TABLE, 10'h3ff, 16'h8000, 5'h00);
        send_item(swla_pkg::OP_TABLE, 10'h000, 16'h7fff, 5'h1f);
        send_item(swla_pkg::OP_TABLE, 10'h021, 16'h0005, 5'h00);
        send_item(swla_pkg::OP_TABLE, 10'h3e0, 16'hfffe, 5'h00);
        send_item(swla_pkg::OP_APPEND_A, 10'h000, 16'h0000, 5'h1f);
        send_item(swla_pkg::OP_APPEND_A, 10'h000, 16'h0000, 5'h00);
        send_item(swla_pkg::OP_APPEND_A, 10'h000, 16'h0000, 5'h01);
        send_item(swla_pkg::OP_APPEND_B, 10'h000, 16'h0000, 5'h00);
        send_item(swla_pkg::OP_APPEND_B, 10'h000, 16'h0000, 5'h01);
        send_item(swla_pkg::OP_APPEND_B, 10'h000, 16'h0000, 5'h1f);
        send_item(swla_pkg::OP_GO, 10'h000, 16'h0000, 5'h00);
        send_item(swla_pkg::OP_APPEND_A, 10'h000, 16'h0000, 5'h1f);
        send_item(swla_pkg::OP_APPEND_B, 10'h000, 16'h0000, 5'h1f);
        send_item(swla_pkg::OP_GO, 10'h000, 16'h0000, 5'h00);
        send_item(swla_pkg::OP_APPEND_A, 10'h000, 16'h0000, 5'h03);
        send_item(swla_pkg::OP_GO, 10'h000, 16'h0000, 5'h00);
    endtask

    // appends past capacity on both sequences are dropped
    task automatic test_full_sequence();
        int n;
        write_gap(16'h7fff);
        for (n = 0; n < 34; n++)
        begin
            send_item(swla_pkg::OP_APPEND_A, 10'($urandom), 16'($urandom), 5'($urandom));
            send_item(swla_pkg::OP_APPEND_B, 10'($urandom), 16'($urandom), 5'($urandom));
        end
        send_item(swla_pkg::OP_GO, 10'($urandom), 16'($urandom), 5'($urandom));
    endtask

    task automatic test_random_phase(int items, int idle, int stall, logic [15:0] g);
        int sent;
        int count;
        write_gap(g);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        count = 0;
        while (count < items)
        begin
            random_job(sent);
            count += sent;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = swla_pkg::OP_TABLE;
        send_idle_pct = 20;
        recv_stall_pct = 56;
        len_a = 0;
        len_b = 0;
        gap = 0;
        foreach (sub_score[i]) sub_score[i] = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_sequence();
        test_random_phase(35, 20, 56, 16'h8000);
        test_random_phase(35, 56, 20, 16'hfffd);
        test_random_phase(35, 0, 0, 16'h0000);
        end_burst();
        while (columns_due.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        column_t got;
        column_t want;
        got = {m_tdata[20:0], m_tdata[26:21], m_tdata[32:27], m_tdata[38:33], m_tlast};
        if (rst_n && m_tvalid && m_tready)
        begin
            if (columns_due.size() == 0)
            begin
                $display("%0t unexpected result: actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = columns_due.pop_front();
                if (got.best !== want.best || got.plen !== want.plen ||
                    got.ia !== want.ia || got.ib !== want.ib || got.last !== want.last)
                begin
                    $display("%0t mismatch: expected best %0d len %0d a %0d b %0d last %0b",
                             $time, want.best, want.plen, $signed(want.ia),
                             $signed(want.ib), want.last);
                    $display("%0t           actual best %0d len %0d a %0d b %0d last %0b",
                             $time, got.best, got.plen, $signed(got.ia),
                             $signed(got.ib), got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

endmodule

// File: smith_waterman_local_align.f
+incdir+src
src/swla_pkg.sv
src/swla_cell.sv
src/smith_waterman_local_align.sv
src/swla_checker.sv
dv/tb_top.sv
